// ===== src/rgim_pkg.sv =====
// rgim_pkg: widths, register codes and pipeline types of the rotated grid mapper
// used by rgim_rotate, rgim_fdiv and rotated_grid_index_mapper_unit
package rgim_pkg;

	localparam int INDEX_BITS = 24;
	localparam int COORD_BITS = 32;

	localparam int CFG_W  = 64;
	localparam int HALF_W = 32;
	localparam int CS_W   = 31;
	localparam int COEF_W = HALF_W + 1;
	localparam int FRAC   = 30;

	// rotation operands and the split into partial products
	localparam int OP_W  = 61;
	localparam int SPLIT = 29;
	localparam int PH_W  = OP_W - SPLIT + COEF_W;
	localparam int PL_W  = SPLIT + 1 + COEF_W;
	localparam int TOT_W = PH_W + SPLIT + 2;
	localparam int ROT_W = TOT_W - FRAC;
	localparam int WX_W  = ROT_W + 1;

	// scaled index, its clamp width and the z sum
	localparam int DX_W  = INDEX_BITS + CS_W + 2;
	localparam int CLW   = (DX_W > OP_W) ? DX_W : OP_W + 1;
	localparam int WZ_W  = ((DX_W > COORD_BITS) ? DX_W : COORD_BITS) + 1;

	// inverse path and divider
	localparam int TX_W  = ((COORD_BITS > HALF_W) ? COORD_BITS : HALF_W) + 1;
	localparam int GX_W  = TX_W + 4;
	localparam int ND    = GX_W;
	localparam int QS_W  = ND + 1;
	localparam int REM_W = CS_W;

	// cycles from the accepting edge to the edge that takes the result
	localparam int LAT = ND + 7;

	typedef enum logic [2:0] {
		REG_ROT      = 3'd0,
		REG_PIVOT    = 3'd1,
		REG_OFFSET   = 3'd2,
		REG_ORIGIN_Z = 3'd3,
		REG_CS_X     = 3'd4,
		REG_CS_Y     = 3'd5,
		REG_CS_Z     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                          func;
		logic [2:0]                    neg;
		logic signed [COORD_BITS-1:0]  wx;
		logic signed [COORD_BITS-1:0]  wy;
		logic signed [COORD_BITS-1:0]  wz;
		logic                          sat;
	} ride_t;

endpackage

// ===== src/rgim_rotate.sv =====
// rgim_rotate: three-stage exact rotation term floor((a*ca + b*cb) / 2^30)
// depends on rgim_pkg
module rgim_rotate import rgim_pkg::*; (
	input  logic                     clk,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	input  logic signed [COEF_W-1:0] ca,
	input  logic signed [COEF_W-1:0] cb,
	output logic signed [ROT_W-1:0]  rot
);

	logic signed [OP_W-SPLIT-1:0] ah, bh;
	logic signed [SPLIT:0]        al, bl;
	logic signed [PH_W-1:0]       pah_s2, pbh_s2;
	logic signed [PL_W-1:0]       pal_s2, pbl_s2;
	logic signed [PH_W:0]         sh_s3;
	logic signed [PL_W:0]         sl_s3;
	logic signed [TOT_W-1:0]      tot;
	logic signed [ROT_W-1:0]      rot_s4;

	// high part keeps the sign, low part is a plain unsigned remainder
	assign ah = $signed(a[OP_W-1:SPLIT]);
	assign bh = $signed(b[OP_W-1:SPLIT]);
	assign al = $signed({1'b0, a[SPLIT-1:0]});
	assign bl = $signed({1'b0, b[SPLIT-1:0]});

	always_ff @(posedge clk) begin
		pah_s2 <= PH_W'(ah) * PH_W'(ca);
		pbh_s2 <= PH_W'(bh) * PH_W'(cb);
		pal_s2 <= PL_W'(al) * PL_W'(ca);
		pbl_s2 <= PL_W'(bl) * PL_W'(cb);
	end

	always_ff @(posedge clk) begin
		sh_s3 <= (PH_W+1)'(pah_s2) + (PH_W+1)'(pbh_s2);
		sl_s3 <= (PL_W+1)'(pal_s2) + (PL_W+1)'(pbl_s2);
	end

	always_comb begin
		tot = (TOT_W'(sh_s3) <<< SPLIT) + TOT_W'(sl_s3);
	end

	// dropping the fraction bits of a two's complement word rounds down
	always_ff @(posedge clk) begin
		rot_s4 <= $signed(tot[TOT_W-1:FRAC]);
	end

	assign rot = rot_s4;

endmodule

// ===== src/rgim_fdiv.sv =====
// rgim_fdiv: restoring divider lane, one quotient bit per register stage
// depends on rgim_pkg
module rgim_fdiv import rgim_pkg::*; (
	input  logic            clk,
	input  logic [ND-1:0]   num,
	input  logic [CS_W-1:0] den,
	output logic [ND-1:0]   quo
);

	logic [REM_W-1:0] rem_sd [ND];
	logic [ND-1:0]    num_sd [ND];
	logic [ND-1:0]    quo_sd [ND];

	for (genvar k = 0; k < ND; k++) begin : g_st
		logic [REM_W-1:0] rp;
		logic [ND-1:0]    np, qp;
		logic [REM_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rp = '0;
			assign np = num;
			assign qp = '0;
		end else begin : g_next
			assign rp = rem_sd[k-1];
			assign np = num_sd[k-1];
			assign qp = quo_sd[k-1];
		end

		assign trial = {rp, np[ND-1]};
		assign ge    = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			rem_sd[k] <= ge ? REM_W'(trial - {1'b0, den}) : REM_W'(trial);
			num_sd[k] <= {np[ND-2:0], 1'b0};
			quo_sd[k] <= {qp[ND-2:0], ge};
		end
	end

	assign quo = quo_sd[ND-1];

endmodule

// ===== src/rotated_grid_index_mapper_unit.sv =====
// rotated_grid_index_mapper_unit: cell index <-> world position for a rotated grid
// depends on rgim_pkg, rgim_rotate and rgim_fdiv
//
// Use: a word is taken at a rising edge where start is high and busy is low.
// busy is held low: one word can be taken in every cycle, in either direction.
// func 0 maps cell_i/j/k to world_x/y/z, func 1 maps point_x/y/z to
// index_i/j/k; the fields of the unused direction read as zero.
// Each result is shown for one cycle with done high, in the order the words
// came in. The divider lanes give one quotient bit per stage (37 stages),
// behind six stages of scaling, rotation and offset arithmetic and ahead of
// one output register.
// saturated is high when any field of that result was clamped.
// The receiver cannot stall, so nothing holds the pipeline.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata), written
// by the user only while no word is in flight; the block does not enforce it.
// Reset clears the valid bits and loads identity rotation, zero pivot, offset
// and origin, and cell sizes of 65536; a cell size written as zero is stored as 1.
module rotated_grid_index_mapper_unit import rgim_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          func,
	input  logic signed [INDEX_BITS-1:0]  cell_i,
	input  logic signed [INDEX_BITS-1:0]  cell_j,
	input  logic signed [INDEX_BITS-1:0]  cell_k,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  point_z,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_idx,
	input  logic [CFG_W-1:0]              cfg_wdata,
	output logic signed [COORD_BITS-1:0]  world_x,
	output logic signed [COORD_BITS-1:0]  world_y,
	output logic signed [COORD_BITS-1:0]  world_z,
	output logic signed [INDEX_BITS-1:0]  index_i,
	output logic signed [INDEX_BITS-1:0]  index_j,
	output logic signed [INDEX_BITS-1:0]  index_k,
	output logic                          saturated
);

	localparam logic signed [CLW-1:0] DX_HI =
		{{(CLW-OP_W+1){1'b0}}, {(OP_W-1){1'b1}}};
	localparam logic signed [CLW-1:0] DX_LO =
		{{(CLW-OP_W+1){1'b1}}, {(OP_W-1){1'b0}}};
	localparam logic signed [WZ_W-1:0] WZ_HI =
		{{(WZ_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [WZ_W-1:0] WZ_LO =
		{{(WZ_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [WX_W-1:0] WX_HI =
		{{(WX_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [WX_W-1:0] WX_LO =
		{{(WX_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [QS_W-1:0] IX_HI =
		{{(QS_W-INDEX_BITS+1){1'b0}}, {(INDEX_BITS-1){1'b1}}};
	localparam logic signed [QS_W-1:0] IX_LO =
		{{(QS_W-INDEX_BITS+1){1'b1}}, {(INDEX_BITS-1){1'b0}}};

	// configuration registers
	logic [CFG_W-1:0]  rot_q, pivot_q, offset_q;
	logic [HALF_W-1:0] origin_z_q;
	logic [CS_W-1:0]   cs_x_q, cs_y_q, cs_z_q;
	logic [CS_W-1:0]   cs_wr;

	assign cs_wr = (cfg_wdata[CS_W-1:0] == '0) ? CS_W'(1) : cfg_wdata[CS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q      <= {2'b01, {(CFG_W-2){1'b0}}};
			pivot_q    <= '0;
			offset_q   <= '0;
			origin_z_q <= '0;
			cs_x_q     <= CS_W'(65536);
			cs_y_q     <= CS_W'(65536);
			cs_z_q     <= CS_W'(65536);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ROT:      rot_q      <= cfg_wdata;
				REG_PIVOT:    pivot_q    <= cfg_wdata;
				REG_OFFSET:   offset_q   <= cfg_wdata;
				REG_ORIGIN_Z: origin_z_q <= cfg_wdata[HALF_W-1:0];
				REG_CS_X:     cs_x_q     <= cs_wr;
				REG_CS_Y:     cs_y_q     <= cs_wr;
				REG_CS_Z:     cs_z_q     <= cs_wr;
				default: ;
			endcase
		end
	end

	logic signed [HALF_W-1:0] cos_v, sin_v, piv_x, piv_y, off_x, off_y, org_z;
	assign cos_v = $signed(rot_q[CFG_W-1:HALF_W]);
	assign sin_v = $signed(rot_q[HALF_W-1:0]);
	assign piv_x = $signed(pivot_q[CFG_W-1:HALF_W]);
	assign piv_y = $signed(pivot_q[HALF_W-1:0]);
	assign off_x = $signed(offset_q[CFG_W-1:HALF_W]);
	assign off_y = $signed(offset_q[HALF_W-1:0]);
	assign org_z = $signed(origin_z_q);

	logic acc;
	assign acc  = start && !busy;
	assign busy = 1'b0;

	// stage 1: scale and offset, or subtract the pivot
	logic signed [DX_W-1:0] dx_full, dy_full;
	logic signed [CLW-1:0]  dx_e, dy_e;
	logic signed [OP_W-1:0] dx_c, dy_c;
	logic                   dsat;
	logic signed [TX_W-1:0] tx, ty, tz;
	logic signed [WZ_W-1:0] wz_full;

	always_comb begin
		dx_full = DX_W'(cell_i) * DX_W'($signed({1'b0, cs_x_q})) + DX_W'(off_x);
		dy_full = DX_W'(cell_j) * DX_W'($signed({1'b0, cs_y_q})) + DX_W'(off_y);
		dx_e = CLW'(dx_full);
		dy_e = CLW'(dy_full);
		dsat = 1'b0;
		if (dx_e > DX_HI) begin
			dx_c = OP_W'(DX_HI);
			dsat = 1'b1;
		end else if (dx_e < DX_LO) begin
			dx_c = OP_W'(DX_LO);
			dsat = 1'b1;
		end else begin
			dx_c = OP_W'(dx_e);
		end
		if (dy_e > DX_HI) begin
			dy_c = OP_W'(DX_HI);
			dsat = 1'b1;
		end else if (dy_e < DX_LO) begin
			dy_c = OP_W'(DX_LO);
			dsat = 1'b1;
		end else begin
			dy_c = OP_W'(dy_e);
		end
		wz_full = WZ_W'(org_z) + WZ_W'(cell_k) * WZ_W'($signed({1'b0, cs_z_q}));
		tx = TX_W'(point_x) - TX_W'(piv_x);
		ty = TX_W'(point_y) - TX_W'(piv_y);
		tz = TX_W'(point_z) - TX_W'(org_z);
	end

	logic                   vld_s1, func_s1, sat_s1;
	logic signed [OP_W-1:0] a_s1, b_s1;
	logic signed [WZ_W-1:0] wz_s1;
	logic signed [TX_W-1:0] tz_s1;

	always_ff @(posedge clk) begin
		func_s1 <= func;
		a_s1    <= func ? OP_W'(tx) : dx_c;
		b_s1    <= func ? OP_W'(ty) : dy_c;
		sat_s1  <= !func && dsat;
		wz_s1   <= wz_full;
		tz_s1   <= tz;
	end

	// stages 2 to 4: rotation, forward by +angle terms, inverse by -angle
	logic signed [COEF_W-1:0] c_e, s_e, ns_e, cxa, cxb, cya, cyb;
	logic signed [ROT_W-1:0]  rx_s4, ry_s4;

	always_comb begin
		c_e  = COEF_W'(cos_v);
		s_e  = COEF_W'(sin_v);
		ns_e = -s_e;
		cxa  = c_e;
		cxb  = func_s1 ? s_e : ns_e;
		cya  = func_s1 ? ns_e : s_e;
		cyb  = c_e;
	end

	rgim_rotate u_rot_x (
		.clk (clk), .a (a_s1), .b (b_s1), .ca (cxa), .cb (cxb), .rot (rx_s4)
	);

	rgim_rotate u_rot_y (
		.clk (clk), .a (a_s1), .b (b_s1), .ca (cya), .cb (cyb), .rot (ry_s4)
	);

	logic                         vld_s2, vld_s3, vld_s4;
	logic                         func_s2, func_s3, func_s4;
	logic                         sat_s2, sat_s3, sat_s4;
	logic signed [COORD_BITS-1:0] wz_s2, wz_s3, wz_s4;
	logic signed [TX_W-1:0]       tz_s2, tz_s3, tz_s4;

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		tz_s2   <= tz_s1;
		if (wz_s1 > WZ_HI) begin
			wz_s2  <= COORD_BITS'(WZ_HI);
			sat_s2 <= sat_s1 || !func_s1;
		end else if (wz_s1 < WZ_LO) begin
			wz_s2  <= COORD_BITS'(WZ_LO);
			sat_s2 <= sat_s1 || !func_s1;
		end else begin
			wz_s2  <= COORD_BITS'(wz_s1);
			sat_s2 <= sat_s1;
		end
		func_s3 <= func_s2;
		sat_s3  <= sat_s2;
		wz_s3   <= wz_s2;
		tz_s3   <= tz_s2;
		func_s4 <= func_s3;
		sat_s4  <= sat_s3;
		wz_s4   <= wz_s3;
		tz_s4   <= tz_s3;
	end

	// stage 5: add the pivot and clamp, or take off the x and y offset
	logic signed [WX_W-1:0] wx_full, wy_full;
	logic signed [COORD_BITS-1:0] wx_c, wy_c;
	logic                   wsat;

	always_comb begin
		wx_full = WX_W'(piv_x) + WX_W'(rx_s4);
		wy_full = WX_W'(piv_y) + WX_W'(ry_s4);
		wsat = 1'b0;
		if (wx_full > WX_HI) begin
			wx_c = COORD_BITS'(WX_HI);
			wsat = 1'b1;
		end else if (wx_full < WX_LO) begin
			wx_c = COORD_BITS'(WX_LO);
			wsat = 1'b1;
		end else begin
			wx_c = COORD_BITS'(wx_full);
		end
		if (wy_full > WX_HI) begin
			wy_c = COORD_BITS'(WX_HI);
			wsat = 1'b1;
		end else if (wy_full < WX_LO) begin
			wy_c = COORD_BITS'(WX_LO);
			wsat = 1'b1;
		end else begin
			wy_c = COORD_BITS'(wy_full);
		end
	end

	logic                         vld_s5, func_s5, sat_s5;
	logic signed [COORD_BITS-1:0] wx_s5, wy_s5, wz_s5;
	logic signed [GX_W-1:0]       gx_s5, gy_s5, gz_s5;

	always_ff @(posedge clk) begin
		func_s5 <= func_s4;
		sat_s5  <= sat_s4 || (!func_s4 && wsat);
		wx_s5   <= wx_c;
		wy_s5   <= wy_c;
		wz_s5   <= wz_s4;
		gx_s5   <= GX_W'(rx_s4) - GX_W'(off_x);
		gy_s5   <= GX_W'(ry_s4) - GX_W'(off_y);
		gz_s5   <= GX_W'(tz_s4);
	end

	// stage 6: floor division of a negative value as -ceil(|v| / d)
	logic          vld_s6;
	ride_t         ride_s6;
	logic [ND-1:0] nx_s6, ny_s6, nz_s6;
	logic [2:0]    neg;

	assign neg = {gz_s5[GX_W-1], gy_s5[GX_W-1], gx_s5[GX_W-1]};

	always_ff @(posedge clk) begin
		ride_s6.func <= func_s5;
		ride_s6.neg  <= neg;
		ride_s6.wx   <= wx_s5;
		ride_s6.wy   <= wy_s5;
		ride_s6.wz   <= wz_s5;
		ride_s6.sat  <= sat_s5;
		nx_s6 <= neg[0] ? ND'(-(GX_W+1)'(gx_s5) + (GX_W+1)'(cs_x_q) - (GX_W+1)'(1))
		                : ND'(gx_s5);
		ny_s6 <= neg[1] ? ND'(-(GX_W+1)'(gy_s5) + (GX_W+1)'(cs_y_q) - (GX_W+1)'(1))
		                : ND'(gy_s5);
		nz_s6 <= neg[2] ? ND'(-(GX_W+1)'(gz_s5) + (GX_W+1)'(cs_z_q) - (GX_W+1)'(1))
		                : ND'(gz_s5);
	end

	logic [ND-1:0] qx, qy, qz;

	rgim_fdiv u_div_x (.clk (clk), .num (nx_s6), .den (cs_x_q), .quo (qx));
	rgim_fdiv u_div_y (.clk (clk), .num (ny_s6), .den (cs_y_q), .quo (qy));
	rgim_fdiv u_div_z (.clk (clk), .num (nz_s6), .den (cs_z_q), .quo (qz));

	// side data rides alongside the divider stages
	ride_t         ride_sd [ND];
	logic [ND-1:0] vld_sd;

	always_ff @(posedge clk) begin
		ride_sd[0] <= ride_s6;
		for (int k = 1; k < ND; k++) begin
			ride_sd[k] <= ride_sd[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_sd <= '0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_sd <= {vld_sd[ND-2:0], vld_s6};
		end
	end

	// output stage: sign the quotients, clamp, blank the unused fields
	ride_t                  rl;
	logic signed [QS_W-1:0] sqx, sqy, sqz;
	logic signed [INDEX_BITS-1:0] ix_c, iy_c, iz_c;
	logic                   isat;

	always_comb begin
		rl  = ride_sd[ND-1];
		sqx = rl.neg[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		sqy = rl.neg[1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		sqz = rl.neg[2] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
		isat = 1'b0;
		if (sqx > IX_HI) begin
			ix_c = INDEX_BITS'(IX_HI);
			isat = 1'b1;
		end else if (sqx < IX_LO) begin
			ix_c = INDEX_BITS'(IX_LO);
			isat = 1'b1;
		end else begin
			ix_c = INDEX_BITS'(sqx);
		end
		if (sqy > IX_HI) begin
			iy_c = INDEX_BITS'(IX_HI);
			isat = 1'b1;
		end else if (sqy < IX_LO) begin
			iy_c = INDEX_BITS'(IX_LO);
			isat = 1'b1;
		end else begin
			iy_c = INDEX_BITS'(sqy);
		end
		if (sqz > IX_HI) begin
			iz_c = INDEX_BITS'(IX_HI);
			isat = 1'b1;
		end else if (sqz < IX_LO) begin
			iz_c = INDEX_BITS'(IX_LO);
			isat = 1'b1;
		end else begin
			iz_c = INDEX_BITS'(sqz);
		end
	end

	logic                         done_q, sat_q;
	logic signed [COORD_BITS-1:0] world_x_q, world_y_q, world_z_q;
	logic signed [INDEX_BITS-1:0] index_i_q, index_j_q, index_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_sd[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		world_x_q <= rl.func ? '0 : rl.wx;
		world_y_q <= rl.func ? '0 : rl.wy;
		world_z_q <= rl.func ? '0 : rl.wz;
		index_i_q <= rl.func ? ix_c : '0;
		index_j_q <= rl.func ? iy_c : '0;
		index_k_q <= rl.func ? iz_c : '0;
		sat_q     <= rl.func ? isat : rl.sat;
	end

	assign done      = done_q;
	assign world_x   = world_x_q;
	assign world_y   = world_y_q;
	assign world_z   = world_z_q;
	assign index_i   = index_i_q;
	assign index_j   = index_j_q;
	assign index_k   = index_k_q;
	assign saturated = sat_q;

`ifndef SYNTH
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("word taken but no result after the pipeline latency");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result without a word taken one latency earlier");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		done && (index_i != 0 || index_j != 0 || index_k != 0) |->
		world_x == 0 && world_y == 0 && world_z == 0)
		else $error("both world and index fields carry data");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> !busy && $past(vld_s1, 5))
		else $error("stage valid bits out of step");
`endif

endmodule

// ===== tb/rotated_grid_index_mapper_unit_test.sv =====
// rotated_grid_index_mapper_unit_test: self-checking bench for the rotated grid mapper
// depends on rgim_pkg and rotated_grid_index_mapper_unit; predicts each word in wide arithmetic
module rotated_grid_index_mapper_unit_test;
	import rgim_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic                         func;
		logic signed [INDEX_BITS-1:0] ci, cj, ck;
		logic signed [COORD_BITS-1:0] px, py, pz;
	} map_word_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] wx, wy, wz;
		logic signed [INDEX_BITS-1:0] ii, ij, ik;
		logic                         sat;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic func = 1'b0;
	logic signed [INDEX_BITS-1:0] cell_i = '0, cell_j = '0, cell_k = '0;
	logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic signed [COORD_BITS-1:0] world_x, world_y, world_z;
	logic signed [INDEX_BITS-1:0] index_i, index_j, index_k;
	logic saturated;

	rotated_grid_index_mapper_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the register file
	logic [63:0] rot_reg, pivot_reg, offset_reg;
	logic [31:0] origin_z_reg;
	logic [30:0] size_x_reg, size_y_reg, size_z_reg;

	map_word_t   pending_words[$];
	map_result_t expected_maps[$];
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          steady = 0;
	bit          drain_hold = 0;

	function automatic wide_t clamp_to(wide_t v, int bits, inout bit flag);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			flag = 1;
			return hi;
		end
		if (v < lo) begin
			flag = 1;
			return lo;
		end
		return v;
	endfunction

	function automatic wide_t floor_quot(wide_t v, wide_t d);
		wide_t q;
		q = v / d;
		if (v % d != 0 && v < 0) q = q - 1;
		return q;
	endfunction

	// zero cell size behaves as the smallest step
	function automatic wide_t step_of(logic [30:0] r);
		return (r == 0) ? wide_t'(1) : wide_t'({1'b0, r});
	endfunction

	function automatic map_result_t map_word(map_word_t w);
		wide_t c, s, pvx, pvy, ofx, ofy, oz, dx, dy, tx, ty, tz, gx, gy, v;
		bit sat;
		map_result_t r;
		c   = wide_t'($signed(rot_reg[63:32]));
		s   = wide_t'($signed(rot_reg[31:0]));
		pvx = wide_t'($signed(pivot_reg[63:32]));
		pvy = wide_t'($signed(pivot_reg[31:0]));
		ofx = wide_t'($signed(offset_reg[63:32]));
		ofy = wide_t'($signed(offset_reg[31:0]));
		oz  = wide_t'($signed(origin_z_reg));
		sat = 0;
		r = '{default: '0};
		if (w.func == 1'b0) begin
			dx = clamp_to(wide_t'(w.ci) * step_of(size_x_reg) + ofx, OP_W, sat);
			dy = clamp_to(wide_t'(w.cj) * step_of(size_y_reg) + ofy, OP_W, sat);
			v = clamp_to(pvx + ((dx * c - dy * s) >>> 30), COORD_BITS, sat);
			r.wx = v[COORD_BITS-1:0];
			v = clamp_to(pvy + ((dx * s + dy * c) >>> 30), COORD_BITS, sat);
			r.wy = v[COORD_BITS-1:0];
			v = clamp_to(oz + wide_t'(w.ck) * step_of(size_z_reg), COORD_BITS, sat);
			r.wz = v[COORD_BITS-1:0];
		end else begin
			tx = wide_t'(w.px) - pvx;
			ty = wide_t'(w.py) - pvy;
			tz = wide_t'(w.pz) - oz;
			gx = ((tx * c + ty * s) >>> 30) - ofx;
			gy = ((ty * c - tx * s) >>> 30) - ofy;
			v = clamp_to(floor_quot(gx, step_of(size_x_reg)), INDEX_BITS, sat);
			r.ii = v[INDEX_BITS-1:0];
			v = clamp_to(floor_quot(gy, step_of(size_y_reg)), INDEX_BITS, sat);
			r.ij = v[INDEX_BITS-1:0];
			v = clamp_to(floor_quot(tz, step_of(size_z_reg)), INDEX_BITS, sat);
			r.ik = v[INDEX_BITS-1:0];
		end
		r.sat = sat;
		return r;
	endfunction

	// driver: a word is taken when start is high and busy low
	always @(posedge clk) begin
		map_word_t w;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy)
				expected_maps.push_back(map_word(
					'{func, cell_i, cell_j, cell_k, point_x, point_y, point_z}));
			if (!(start && busy)) begin
				if (pending_words.size() > 0 && !drain_hold
						&& (steady || $urandom_range(99) >= 10)) begin
					w = pending_words.pop_front();
					start   <= 1'b1;
					func    <= w.func;
					cell_i  <= w.ci;
					cell_j  <= w.cj;
					cell_k  <= w.ck;
					point_x <= w.px;
					point_y <= w.py;
					point_z <= w.pz;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		map_result_t e;
		if (arst_n && done) begin
			if (expected_maps.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				e = expected_maps.pop_front();
				if (world_x !== e.wx) begin
					$error("world_x exp %0d got %0d", e.wx, world_x);
					fail_count++;
				end
				if (world_y !== e.wy) begin
					$error("world_y exp %0d got %0d", e.wy, world_y);
					fail_count++;
				end
				if (world_z !== e.wz) begin
					$error("world_z exp %0d got %0d", e.wz, world_z);
					fail_count++;
				end
				if (index_i !== e.ii) begin
					$error("index_i exp %0d got %0d", e.ii, index_i);
					fail_count++;
				end
				if (index_j !== e.ij) begin
					$error("index_j exp %0d got %0d", e.ij, index_j);
					fail_count++;
				end
				if (index_k !== e.ik) begin
					$error("index_k exp %0d got %0d", e.ik, index_k);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %0d got %0d", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > 300000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_ROT:      rot_reg = data;
			REG_PIVOT:    pivot_reg = data;
			REG_OFFSET:   offset_reg = data;
			REG_ORIGIN_Z: origin_z_reg = data[31:0];
			REG_CS_X:     size_x_reg = data[30:0];
			REG_CS_Y:     size_y_reg = data[30:0];
			REG_CS_Z:     size_z_reg = data[30:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || expected_maps.size() > 0 || start)
			@(posedge clk);
	endtask

	function automatic map_word_t random_word();
		map_word_t w;
		w.func = 1'($urandom_range(1));
		w.ci = 24'($urandom);
		w.cj = 24'($urandom);
		w.ck = 24'($urandom);
		w.px = 32'($urandom);
		w.py = 32'($urandom);
		w.pz = 32'($urandom);
		// mostly keep the operands near the grid so the results stay in range
		if ($urandom_range(3) != 0) begin
			w.ci = $signed(24'($urandom_range(400))) - 24'sd200;
			w.cj = $signed(24'($urandom_range(400))) - 24'sd200;
			w.ck = $signed(24'($urandom_range(400))) - 24'sd200;
			w.px = $signed(32'($urandom_range(32'h0400_0000))) - 32'sh0200_0000;
			w.py = $signed(32'($urandom_range(32'h0400_0000))) - 32'sh0200_0000;
			w.pz = $signed(32'($urandom_range(32'h0400_0000))) - 32'sh0200_0000;
		end
		return w;
	endfunction

	task automatic random_config();
		logic [31:0] cs, sn;
		case ($urandom_range(4))
			0: begin cs = 32'h4000_0000; sn = 32'd0; end
			1: begin cs = 32'd644245094; sn = 32'd858993459; end
			2: begin cs = -32'sd858993459; sn = 32'd644245094; end
			3: begin cs = 32'd0; sn = -32'sh4000_0000; end
			default: begin cs = $urandom; sn = $urandom; end
		endcase
		write_reg(REG_ROT, {cs, sn});
		write_reg(REG_PIVOT, {$urandom, $urandom} & 64'h00ff_ffff_00ff_ffff);
		write_reg(REG_OFFSET, {$urandom, $urandom} & 64'h00ff_ffff_00ff_ffff);
		write_reg(REG_ORIGIN_Z, 64'($urandom & 32'h00ff_ffff));
		write_reg(REG_CS_X, 64'($urandom_range(32'h0004_0000, 32'h0000_1000)));
		write_reg(REG_CS_Y, 64'($urandom_range(32'h0004_0000, 32'h0000_1000)));
		write_reg(REG_CS_Z, 64'($urandom_range(32'h0004_0000, 32'h0000_1000)));
	endtask

	initial begin
		map_word_t w;
		rot_reg = 64'h4000_0000_0000_0000;
		pivot_reg = 64'd0;
		offset_reg = 64'd0;
		origin_z_reg = 32'd0;
		size_x_reg = 31'd65536;
		size_y_reg = 31'd65536;
		size_z_reg = 31'd65536;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of every field in both directions at reset settings
		for (int n = 0; n < 4; n++) begin
			w.func = 1'b0;
			w.ci = (n == 0) ? 24'sh7f_ffff : (n == 1) ? 24'sh80_0000 :
				(n == 2) ? 24'sd0 : -24'sd1;
			w.cj = (n == 1) ? 24'sh7f_ffff : (n == 0) ? 24'sh80_0000 :
				(n == 3) ? 24'sd0 : -24'sd1;
			w.ck = w.ci;
			w.px = 32'sd0; w.py = 32'sd0; w.pz = 32'sd0;
			pending_words.push_back(w);
			w.func = 1'b1;
			w.px = (n == 0) ? 32'sh7fff_ffff : (n == 1) ? 32'sh8000_0000 :
				(n == 2) ? 32'sd0 : -32'sd1;
			w.py = (n == 1) ? 32'sh7fff_ffff : (n == 0) ? 32'sh8000_0000 :
				(n == 3) ? 32'sd0 : -32'sd1;
			w.pz = w.px;
			pending_words.push_back(w);
		end
		wait_idle();

		// zero cell sizes act as the smallest step; extreme rotation and offsets
		write_reg(REG_CS_X, 64'd0);
		write_reg(REG_CS_Y, 64'd0);
		write_reg(REG_CS_Z, 64'd0);
		write_reg(REG_ROT, 64'h8000_0000_7fff_ffff);
		write_reg(REG_PIVOT, 64'h7fff_ffff_8000_0000);
		write_reg(REG_OFFSET, 64'h8000_0000_7fff_ffff);
		write_reg(REG_ORIGIN_Z, 64'h0000_0000_8000_0000);
		for (int n = 0; n < 8; n++) pending_words.push_back(random_word());
		wait_idle();
		write_reg(REG_CS_X, 64'h7fff_ffff);
		write_reg(REG_CS_Y, 64'h7fff_ffff);
		write_reg(REG_CS_Z, 64'h7fff_ffff);
		write_reg(REG_ROT, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_ORIGIN_Z, 64'h7fff_ffff);
		for (int n = 0; n < 8; n++) pending_words.push_back(random_word());
		wait_idle();

		// random phases, each under its own settings
		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			steady = (phase == 3);
			for (int n = 0; n < 60; n++) pending_words.push_back(random_word());
			if (phase == 5) begin
				while (pending_words.size() > 30) @(posedge clk);
				drain_hold = 1;
				while (expected_maps.size() > 0) @(posedge clk);
				drain_hold = 0;
			end
			wait_idle();
		end

		repeat (LAT + 10) @(posedge clk);
		if (fail_count == 0 && expected_maps.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== rotated_grid_index_mapper_unit.f =====
src/rgim_pkg.sv
src/rgim_rotate.sv
src/rgim_fdiv.sv
src/rotated_grid_index_mapper_unit.sv
tb/rotated_grid_index_mapper_unit_test.sv
